// File: hdl/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
package spq_pkg;

  localparam int DEPTH   = 16;
  localparam int VALUE_W = 32;
  localparam int PRIO_W  = 16;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int IDX_W   = $clog2(DEPTH);

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_OVERFLOW  = 2'd2
  } status_t;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_t;

  // Broadcast from the top level to every cell of the chain.
  typedef struct packed {
    logic                      ins_en;
    logic                      rem_en;
    logic                      head_first;
    logic [CNT_W-1:0]          cnt;
    logic signed [VALUE_W-1:0] new_value;
    logic signed [PRIO_W-1:0]  new_prio;
  } cell_ctl_t;

endpackage

// File: hdl/spq_cell.sv
// One slot of the sorted chain: holds an entry and shifts with its neighbors.
module spq_cell (
  input  logic                              clk,
  input  logic [spq_pkg::IDX_W-1:0]         idx,
  input  spq_pkg::cell_ctl_t                ctl,
  input  logic                              prev_ge,
  input  logic signed [spq_pkg::VALUE_W-1:0] prev_value,
  input  logic signed [spq_pkg::PRIO_W-1:0]  prev_prio,
  input  logic signed [spq_pkg::VALUE_W-1:0] next_value,
  input  logic signed [spq_pkg::PRIO_W-1:0]  next_prio,
  output logic                              ge,
  output logic signed [spq_pkg::VALUE_W-1:0] value,
  output logic signed [spq_pkg::PRIO_W-1:0]  prio
);
  import spq_pkg::*;

  logic is_head;
  logic at_tail;

  // ge: the new entry lands at this slot or above it
  assign is_head = (idx == '0);
  assign at_tail = (CNT_W'(idx) >= ctl.cnt);
  assign ge      = is_head ? ctl.head_first
                           : (ctl.head_first || at_tail || (prio <= ctl.new_prio));

  always_ff @(posedge clk) begin
    if (ctl.ins_en) begin
      if (ge && !prev_ge) begin
        value <= ctl.new_value;
        prio  <= ctl.new_prio;
      end else if (ge) begin
        value <= prev_value;
        prio  <= prev_prio;
      end
    end else if (ctl.rem_en) begin
      value <= next_value;
      prio  <= next_prio;
    end
  end

endmodule

// File: hdl/sorted_priority_queue_unit.sv
// Top level of the sorted priority queue: a chain of entry cells and the count.
//
// Usage:
//   Raise start with kind, value and priority_req to issue a request. A request
//   is taken at any rising edge where start is high and busy is low; busy is
//   never raised, so one request can be taken in every cycle.
//   kind selects insert (OP_INSERT) or remove head (OP_REMOVE).
//   Every request yields exactly one result: done is high for one cycle, in the
//   cycle after the request is taken, with status, count, empty_res,
//   head_value and head_priority describing the queue after that request.
//   Throughput is one request per cycle: every cell compares its priority
//   against the new one at once and all cells shift together, so no search
//   walks the chain.
//   Status is ok, underflow (remove on an empty queue, nothing changes) or
//   overflow (insert on a full queue, the entry is dropped).
//   An empty queue reports head_value of all ones and head_priority of zero.
//   The receiver cannot stall: a result shows for exactly its one cycle.
//   Reset (rst, synchronous) empties the queue and clears done; the entry
//   cells are not cleared, since only slots below count are ever shown.
module sorted_priority_queue_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic                                kind,
  input  logic signed [spq_pkg::VALUE_W-1:0]  value,
  input  logic signed [spq_pkg::PRIO_W-1:0]   priority_req,
  output logic                                done,
  output logic [1:0]                          status,
  output logic [spq_pkg::CNT_W-1:0]           count,
  output logic                                empty_res,
  output logic signed [spq_pkg::VALUE_W-1:0]  head_value,
  output logic signed [spq_pkg::PRIO_W-1:0]   head_priority
);
  import spq_pkg::*;

  logic                      accept;
  logic                      is_full;
  logic                      queue_empty;
  logic                      do_insert;
  logic                      do_remove;
  status_t                   status_next;
  status_t                   status_reg;
  logic [CNT_W-1:0]          count_next;
  cell_ctl_t                 ctl;

  logic                      cell_ge    [DEPTH];
  logic signed [VALUE_W-1:0] cell_value [DEPTH];
  logic signed [PRIO_W-1:0]  cell_prio  [DEPTH];

  // Requests are never held off.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign is_full     = (count == CNT_W'(DEPTH));
  assign queue_empty = (count == '0);

  // Decide the request outcome; a failing request leaves the chain alone.
  always_comb begin
    do_insert   = 1'b0;
    do_remove   = 1'b0;
    status_next = ST_OK;
    count_next  = count;
    if (accept) begin
      if (op_t'(kind) == OP_INSERT) begin
        if (is_full) begin
          status_next = ST_OVERFLOW;
        end else begin
          do_insert  = 1'b1;
          count_next = count + CNT_W'(1);
        end
      end else begin
        if (queue_empty) begin
          status_next = ST_UNDERFLOW;
        end else begin
          do_remove  = 1'b1;
          count_next = count - CNT_W'(1);
        end
      end
    end
  end

  // Broadcast to the cells. head_first: new entry beats the head strictly.
  always_comb begin
    ctl.ins_en     = do_insert;
    ctl.rem_en     = do_remove;
    ctl.head_first = queue_empty || (priority_req > cell_prio[0]);
    ctl.cnt        = count;
    ctl.new_value  = value;
    ctl.new_prio   = priority_req;
  end

  // Chain of cells: slot 0 is the head, data shifts down on insert, up on remove.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                      up_ge;
    logic signed [VALUE_W-1:0] up_value;
    logic signed [PRIO_W-1:0]  up_prio;
    logic signed [VALUE_W-1:0] dn_value;
    logic signed [PRIO_W-1:0]  dn_prio;

    if (i == 0) begin : g_first
      assign up_ge    = 1'b0;
      assign up_value = value;
      assign up_prio  = priority_req;
    end else begin : g_mid
      assign up_ge    = cell_ge[i-1];
      assign up_value = cell_value[i-1];
      assign up_prio  = cell_prio[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      // The tail slot falls out of range on remove; its content no longer counts.
      assign dn_value = cell_value[i];
      assign dn_prio  = cell_prio[i];
    end else begin : g_inner
      assign dn_value = cell_value[i+1];
      assign dn_prio  = cell_prio[i+1];
    end

    spq_cell u_cell (
      .clk        (clk),
      .idx        (IDX_W'(i)),
      .ctl        (ctl),
      .prev_ge    (up_ge),
      .prev_value (up_value),
      .prev_prio  (up_prio),
      .next_value (dn_value),
      .next_prio  (dn_prio),
      .ge         (cell_ge[i]),
      .value      (cell_value[i]),
      .prio       (cell_prio[i])
    );
  end

  // Advance count and latch the result strobe and status.
  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      done       <= 1'b0;
      status_reg <= ST_OK;
    end else begin
      count      <= count_next;
      done       <= accept;
      status_reg <= status_next;
    end
  end

  // The result reads the updated head straight from cell 0.
  assign status        = status_reg;
  assign empty_res     = queue_empty;
  assign head_value    = queue_empty ? '1 : cell_value[0];
  assign head_priority = queue_empty ? '0 : cell_prio[0];

  // Every taken request gives a result on the next cycle.
  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> done)
    else $error("request taken without a result");

  // The count never passes the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("count above capacity");

  // An underflow result always reports an empty queue.
  a_underflow_empty: assert property (@(posedge clk) disable iff (rst)
    (done && status_reg == ST_UNDERFLOW) |-> empty_res)
    else $error("underflow on a non-empty queue");

  // The head never ranks below the second entry.
  a_head_order: assert property (@(posedge clk) disable iff (rst)
    (count >= CNT_W'(2)) |-> (cell_prio[0] >= cell_prio[1]))
    else $error("head out of order");

endmodule
